// ===== design/image_bilinear_resampler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear resampler
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef IMAGE_BILINEAR_RESAMPLER_MACROS_SVH
`define IMAGE_BILINEAR_RESAMPLER_MACROS_SVH

// Check a consequence in the same cycle.
`define IBR_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the following cycle.
`define IBR_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ibr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibr_pkg
// Types, widths and constants shared by the bilinear resampler modules.
// ----------------------------------------------------------------------------
package ibr_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned STEP_W   = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned POS_W    = COORD_W + STEP_W;
  localparam int unsigned INT_W    = POS_W - FRAC_W;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned PIXEL_W  = 4 * CHAN_W;
  localparam int unsigned WEIGHT_W = 2 * FRAC_W + 1;
  localparam int unsigned ACC_W    = WEIGHT_W + CHAN_W - 1;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RST = 9'd256;
  localparam logic [STEP_W-1:0] STEP_RST          = 24'h010000;

  localparam logic FILTER_NEAREST  = 1'b0;
  localparam logic FILTER_BILINEAR = 1'b1;
  localparam logic FILTER_RST      = FILTER_BILINEAR;

  localparam logic [1:0] STEP_FIRST         = 2'd0;
  localparam logic [1:0] STEP_LAST_BILINEAR = 2'd3;

  localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;

  typedef enum logic {
    KIND_STORE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_STEP_X        = 3'd2,
    REG_STEP_Y        = 3'd3,
    REG_FILTER_MODE   = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

endpackage
`default_nettype wire

// ===== design/image_bilinear_resampler.sv =====
// Datapath: the input stage registers a transaction, the access sequencer then writes
// a store or reads a sample's pixels, and the weighted sum goes to the result queue.
// Throughput: one store or nearest sample per cycle, but samples wait while FIFO_DEPTH
// results are pending; a bilinear sample makes four reads through the single store port.
// Reset: clears control state and restores the register defaults; the pixel store
// has no clearing pass and holds nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "image_bilinear_resampler_macros.svh"
// ----------------------------------------------------------------------------
// image_bilinear_resampler
// RGBA8 source-pixel store with nearest and bilinear sampling at scaled
// destination coordinates.
// ----------------------------------------------------------------------------
module image_bilinear_resampler #(
  parameter int unsigned MAX_WIDTH  = ibr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ibr_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // coord_x, coord_y, in_red, in_green, in_blue, in_alpha
  input  logic [55:0] s_axis_tdata,
  // kind
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned IX_W    = ibr_pkg::INT_W + 1;
  localparam int unsigned FIFO_AW = $clog2(ibr_pkg::FIFO_DEPTH);
  localparam int unsigned PEND_W  = $clog2(ibr_pkg::FIFO_DEPTH + 1);

  // configuration registers
  logic [ibr_pkg::SIZE_W-1:0] cfg_source_width;
  logic [ibr_pkg::SIZE_W-1:0] cfg_source_height;
  logic [ibr_pkg::STEP_W-1:0] cfg_step_x;
  logic [ibr_pkg::STEP_W-1:0] cfg_step_y;
  logic                       cfg_filter_mode;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_source_width  <= ibr_pkg::SOURCE_WIDTH_RST;
      cfg_source_height <= ibr_pkg::SOURCE_HEIGHT_RST;
      cfg_step_x        <= ibr_pkg::STEP_RST;
      cfg_step_y        <= ibr_pkg::STEP_RST;
      cfg_filter_mode   <= ibr_pkg::FILTER_RST;
    end else if (cfg_write) begin
      unique case (ibr_pkg::reg_index_t'(paddr[4:2]))
        ibr_pkg::REG_SOURCE_WIDTH:  cfg_source_width  <= pwdata[ibr_pkg::SIZE_W-1:0];
        ibr_pkg::REG_SOURCE_HEIGHT: cfg_source_height <= pwdata[ibr_pkg::SIZE_W-1:0];
        ibr_pkg::REG_STEP_X:        cfg_step_x        <= pwdata[ibr_pkg::STEP_W-1:0];
        ibr_pkg::REG_STEP_Y:        cfg_step_y        <= pwdata[ibr_pkg::STEP_W-1:0];
        ibr_pkg::REG_FILTER_MODE:   cfg_filter_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ibr_pkg::reg_index_t'(paddr[4:2]))
      ibr_pkg::REG_SOURCE_WIDTH:  prdata = 32'(cfg_source_width);
      ibr_pkg::REG_SOURCE_HEIGHT: prdata = 32'(cfg_source_height);
      ibr_pkg::REG_STEP_X:        prdata = 32'(cfg_step_x);
      ibr_pkg::REG_STEP_Y:        prdata = 32'(cfg_step_y);
      ibr_pkg::REG_FILTER_MODE:   prdata = 32'(cfg_filter_mode);
      default:                    prdata = '0;
    endcase
  end

  // last valid column and row of the source image
  logic [XW-1:0] w_last;
  logic [YW-1:0] h_last;

  always_comb begin
    if (cfg_source_width == '0) begin
      w_last = '0;
    end else if (32'(cfg_source_width) > MAX_WIDTH) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(cfg_source_width - 9'd1);
    end
    if (cfg_source_height == '0) begin
      h_last = '0;
    end else if (32'(cfg_source_height) > MAX_HEIGHT) begin
      h_last = YW'(MAX_HEIGHT - 1);
    end else begin
      h_last = YW'(cfg_source_height - 9'd1);
    end
  end

  // input stage: capture the transaction and scale the coordinates
  logic                          in_accept;
  logic [ibr_pkg::COORD_W-1:0]   in_cx;
  logic [ibr_pkg::COORD_W-1:0]   in_cy;
  ibr_pkg::pixel_t               in_pixel;
  ibr_pkg::kind_t                in_kind;

  logic                          s1_valid;
  logic                          s1_take;
  ibr_pkg::kind_t                s1_kind;
  logic [ibr_pkg::COORD_W-1:0]   s1_cx;
  logic [ibr_pkg::COORD_W-1:0]   s1_cy;
  ibr_pkg::pixel_t               s1_pixel;
  logic [ibr_pkg::POS_W-1:0]     s1_pos_x;
  logic [ibr_pkg::POS_W-1:0]     s1_pos_y;

  assign in_cx     = s_axis_tdata[11:0];
  assign in_cy     = s_axis_tdata[23:12];
  assign in_pixel  = ibr_pkg::pixel_t'(s_axis_tdata[55:24]);
  assign in_kind   = ibr_pkg::kind_t'(s_axis_tuser[0]);
  assign s_axis_tready = !s1_valid || s1_take;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind  <= in_kind;
      s1_cx    <= in_cx;
      s1_cy    <= in_cy;
      s1_pixel <= in_pixel;
      s1_pos_x <= ibr_pkg::POS_W'(in_cx) * ibr_pkg::POS_W'(cfg_step_x);
      s1_pos_y <= ibr_pkg::POS_W'(in_cy) * ibr_pkg::POS_W'(cfg_step_y);
    end
  end

  // neighbour and nearest positions, clamped to the image
  logic [ibr_pkg::INT_W-1:0]  ix;
  logic [ibr_pkg::INT_W-1:0]  iy;
  logic [ibr_pkg::FRAC_W-1:0] fx;
  logic [ibr_pkg::FRAC_W-1:0] fy;
  logic [IX_W-1:0]            ix1;
  logic [IX_W-1:0]            iy1;
  logic [IX_W-1:0]            xn_raw;
  logic [IX_W-1:0]            yn_raw;
  logic [XW-1:0]              x0_c;
  logic [XW-1:0]              x1_c;
  logic [XW-1:0]              xn_c;
  logic [YW-1:0]              y0_c;
  logic [YW-1:0]              y1_c;
  logic [YW-1:0]              yn_c;
  logic                       store_in_range;

  assign ix  = s1_pos_x[ibr_pkg::POS_W-1:ibr_pkg::FRAC_W];
  assign iy  = s1_pos_y[ibr_pkg::POS_W-1:ibr_pkg::FRAC_W];
  assign fx  = s1_pos_x[ibr_pkg::FRAC_W-1:0];
  assign fy  = s1_pos_y[ibr_pkg::FRAC_W-1:0];
  assign ix1 = {1'b0, ix} + IX_W'(1);
  assign iy1 = {1'b0, iy} + IX_W'(1);

  always_comb begin
    xn_raw = fx[ibr_pkg::FRAC_W-1] ? ix1 : {1'b0, ix};
    yn_raw = fy[ibr_pkg::FRAC_W-1] ? iy1 : {1'b0, iy};
    x0_c = (ix > ibr_pkg::INT_W'(w_last)) ? w_last : ix[XW-1:0];
    y0_c = (iy > ibr_pkg::INT_W'(h_last)) ? h_last : iy[YW-1:0];
    x1_c = (ix1 > IX_W'(w_last)) ? w_last : ix1[XW-1:0];
    y1_c = (iy1 > IX_W'(h_last)) ? h_last : iy1[YW-1:0];
    xn_c = (xn_raw > IX_W'(w_last)) ? w_last : xn_raw[XW-1:0];
    yn_c = (yn_raw > IX_W'(h_last)) ? h_last : yn_raw[YW-1:0];
    store_in_range = (32'(s1_cx) < MAX_WIDTH) && (32'(s1_cy) < MAX_HEIGHT);
  end

  // access sequencer: one store access per cycle
  logic                       seq_valid;
  logic                       seq_done;
  logic                       seq_free;
  ibr_pkg::kind_t             seq_kind;
  logic                       seq_wr_en;
  logic [1:0]                 seq_step;
  logic [1:0]                 seq_last_step;
  logic [XW-1:0]              seq_x0;
  logic [XW-1:0]              seq_x1;
  logic [YW-1:0]              seq_y0;
  logic [YW-1:0]              seq_y1;
  logic [ibr_pkg::FRAC_W-1:0] seq_fx;
  logic [ibr_pkg::FRAC_W-1:0] seq_fy;
  ibr_pkg::pixel_t            seq_wdata;

  logic [PEND_W-1:0]          pend;
  logic                       pend_ok;
  logic                       pend_inc;

  assign seq_done = seq_valid && (seq_step == seq_last_step);
  assign seq_free = !seq_valid || seq_done;
  assign pend_ok  = pend < PEND_W'(ibr_pkg::FIFO_DEPTH);
  assign s1_take  = s1_valid && seq_free && ((s1_kind == ibr_pkg::KIND_STORE) || pend_ok);
  assign pend_inc = s1_take && (s1_kind == ibr_pkg::KIND_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= 1'b0;
      seq_step  <= ibr_pkg::STEP_FIRST;
    end else if (s1_take) begin
      seq_valid <= 1'b1;
      seq_step  <= ibr_pkg::STEP_FIRST;
    end else if (seq_done) begin
      seq_valid <= 1'b0;
    end else if (seq_valid) begin
      seq_step <= seq_step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      seq_kind  <= s1_kind;
      seq_wdata <= s1_pixel;
      seq_wr_en <= store_in_range;
      if (s1_kind == ibr_pkg::KIND_STORE) begin
        seq_x0        <= s1_cx[XW-1:0];
        seq_x1        <= s1_cx[XW-1:0];
        seq_y0        <= s1_cy[YW-1:0];
        seq_y1        <= s1_cy[YW-1:0];
        seq_fx        <= '0;
        seq_fy        <= '0;
        seq_last_step <= ibr_pkg::STEP_FIRST;
      end else if (cfg_filter_mode == ibr_pkg::FILTER_BILINEAR) begin
        seq_x0        <= x0_c;
        seq_x1        <= x1_c;
        seq_y0        <= y0_c;
        seq_y1        <= y1_c;
        seq_fx        <= fx;
        seq_fy        <= fy;
        seq_last_step <= ibr_pkg::STEP_LAST_BILINEAR;
      end else begin
        seq_x0        <= xn_c;
        seq_x1        <= xn_c;
        seq_y0        <= yn_c;
        seq_y1        <= yn_c;
        seq_fx        <= '0;
        seq_fy        <= '0;
        seq_last_step <= ibr_pkg::STEP_FIRST;
      end
    end
  end

  // address and bilinear weight of the current access
  logic [XW-1:0]                col;
  logic [YW-1:0]                row;
  logic [AW-1:0]                ram_addr;
  logic                         ram_we;
  logic [ibr_pkg::PIXEL_W-1:0]  ram_q;
  logic [ibr_pkg::FRAC_W:0]     wx;
  logic [ibr_pkg::FRAC_W:0]     wy;
  logic [ibr_pkg::WEIGHT_W-1:0] weight;

  always_comb begin
    col      = seq_step[0] ? seq_x1 : seq_x0;
    row      = seq_step[1] ? seq_y1 : seq_y0;
    ram_addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    ram_we   = seq_valid && (seq_kind == ibr_pkg::KIND_STORE) && seq_wr_en;
    wx = seq_step[0] ? {1'b0, seq_fx} : (ibr_pkg::FRAC_ONE - {1'b0, seq_fx});
    wy = seq_step[1] ? {1'b0, seq_fy} : (ibr_pkg::FRAC_ONE - {1'b0, seq_fy});
    weight = ibr_pkg::WEIGHT_W'(34'(wx) * 34'(wy));
  end

  ibr_ram #(
    .WIDTH(ibr_pkg::PIXEL_W),
    .DEPTH(DEPTH)
  ) u_pixel_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(seq_wdata),
    .rdata(ram_q)
  );

  // read return: weights aligned with the store data
  logic                         rd_valid;
  logic                         rd_first;
  logic                         rd_last;
  logic [ibr_pkg::WEIGHT_W-1:0] rd_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= seq_valid && (seq_kind == ibr_pkg::KIND_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    rd_first  <= seq_step == ibr_pkg::STEP_FIRST;
    rd_last   <= seq_done;
    rd_weight <= weight;
  end

  // weighted sum per channel
  logic [ibr_pkg::ACC_W-1:0]   acc      [4];
  logic [ibr_pkg::ACC_W-1:0]   acc_next [4];
  logic [ibr_pkg::PIXEL_W-1:0] res_pixel;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc_next[k] = (rd_first ? '0 : acc[k])
                  + ibr_pkg::ACC_W'(ram_q[ibr_pkg::CHAN_W*k +: ibr_pkg::CHAN_W])
                  * ibr_pkg::ACC_W'(rd_weight);
      res_pixel[ibr_pkg::CHAN_W*k +: ibr_pkg::CHAN_W] =
        acc_next[k][ibr_pkg::ACC_W-1 -: ibr_pkg::CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      for (int k = 0; k < 4; k++) begin
        acc[k] <= acc_next[k];
      end
    end
  end

  // result queue
  logic [ibr_pkg::PIXEL_W-1:0] fifo_mem [ibr_pkg::FIFO_DEPTH];
  logic [FIFO_AW-1:0]          wr_ptr;
  logic [FIFO_AW-1:0]          rd_ptr;
  logic [PEND_W-1:0]           fifo_count;
  logic                        fifo_push;
  logic                        fifo_pop;

  assign fifo_push     = rd_valid && rd_last;
  assign m_axis_tvalid = fifo_count != '0;
  assign m_axis_tdata  = fifo_mem[rd_ptr];
  assign fifo_pop      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[wr_ptr] <= res_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
      pend       <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (fifo_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + PEND_W'(fifo_push) - PEND_W'(fifo_pop);
      pend       <= pend + PEND_W'(pend_inc) - PEND_W'(fifo_pop);
    end
  end

  `IBR_CHECK(queue_within_pending, 1'b1, fifo_count <= pend, "result queue exceeds pending samples")
  `IBR_CHECK_NEXT(sequencer_advances, seq_valid && !seq_done, seq_valid && (seq_step == $past(seq_step) + 2'd1), "sequencer skipped an access")
  `IBR_CHECK_NEXT(result_enqueued, fifo_push && !fifo_pop, fifo_count == $past(fifo_count) + PEND_W'(1), "finished sample not queued")

endmodule
`default_nettype wire

// ===== design/ibr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibr_ram
// Single-port synchronous RAM with a registered read, read-first.
// ----------------------------------------------------------------------------
module ibr_ram #(
  parameter int unsigned WIDTH = ibr_pkg::PIXEL_W,
  parameter int unsigned DEPTH = ibr_pkg::MAX_WIDTH_DEF * ibr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== test/tb_image_bilinear_resampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_image_bilinear_resampler
// Self-checking bench for the bilinear resampler. The bench loads source
// pixels, programs sizes, steps and filter mode over APB while the block is
// quiet, and streams store and sample transactions with random gaps on both
// sides. A shadow pixel store and an exact fixed-point resampler predict each
// sampled pixel, and every output transaction is compared channel by channel.
// ----------------------------------------------------------------------------
module tb_image_bilinear_resampler;
  import ibr_pkg::*;

  localparam int unsigned MAX_W        = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H        = MAX_HEIGHT_DEF;
  localparam int          ITEM_TARGET  = 1450;
  localparam int          PHASE_ITEMS  = 120;
  localparam int          QUIET_CYCLES = 16;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] y;
    logic [11:0] x;
    pixel_t      pix;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  request_t request_queue[$];
  pixel_t   expected_pixels[$];
  pixel_t   shadow_pixels[MAX_W*MAX_H];
  bit       filled[MAX_W*MAX_H];

  logic [SIZE_W-1:0] cfg_width  = SOURCE_WIDTH_RST;
  logic [SIZE_W-1:0] cfg_height = SOURCE_HEIGHT_RST;
  logic [STEP_W-1:0] cfg_step_x = STEP_RST;
  logic [STEP_W-1:0] cfg_step_y = STEP_RST;
  logic              cfg_filter = FILTER_RST;

  int region_w;
  int region_h;
  int item_count;
  int mismatch_count;
  int cycle_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit pressure_armed = 1'b0;
  bit pressure_used = 1'b0;

  image_bilinear_resampler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [20:0] clamp_edge(input logic [20:0] v,
                                             input logic [SIZE_W-1:0] size);
    return (v >= size) ? size - 1 : v;
  endfunction

  function automatic pixel_t resample_pixel(input logic [11:0] cx, input logic [11:0] cy);
    logic [SIZE_W-1:0] w, h;
    logic [35:0]       pos_x, pos_y;
    logic [20:0]       ix, iy, x0, x1, y0, y1;
    logic [15:0]       fx, fy;
    logic [16:0]       gx, gy;
    logic [24:0]       top, bot;
    logic [41:0]       acc;
    pixel_t            tl, tr, bl, br, res;
    w     = eff_size(cfg_width, MAX_W);
    h     = eff_size(cfg_height, MAX_H);
    pos_x = cx * cfg_step_x;
    pos_y = cy * cfg_step_y;
    ix    = pos_x[35:16];
    iy    = pos_y[35:16];
    fx    = pos_x[15:0];
    fy    = pos_y[15:0];
    if (cfg_filter == FILTER_NEAREST) begin
      x0 = clamp_edge((fx < 16'h8000) ? ix : ix + 21'd1, w);
      y0 = clamp_edge((fy < 16'h8000) ? iy : iy + 21'd1, h);
      return shadow_pixels[y0 * MAX_W + x0];
    end
    x0 = clamp_edge(ix, w);
    x1 = clamp_edge(ix + 21'd1, w);
    y0 = clamp_edge(iy, h);
    y1 = clamp_edge(iy + 21'd1, h);
    tl = shadow_pixels[y0 * MAX_W + x0];
    tr = shadow_pixels[y0 * MAX_W + x1];
    bl = shadow_pixels[y1 * MAX_W + x0];
    br = shadow_pixels[y1 * MAX_W + x1];
    gx = FRAC_ONE - fx;
    gy = FRAC_ONE - fy;
    for (int k = 0; k < 4; k++) begin
      top = tl[8*k +: 8] * gx + tr[8*k +: 8] * fx;
      bot = bl[8*k +: 8] * gx + br[8*k +: 8] * fx;
      acc = top * gy + bot * fy;
      res[8*k +: 8] = acc[39:32];
    end
    return res;
  endfunction

  // Driver: offer queued requests and predict each accepted one.
  always @(posedge clk) begin : driver
    request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == KIND_STORE) begin
          if (s_axis_tdata[11:0] < MAX_W && s_axis_tdata[23:12] < MAX_H)
            shadow_pixels[s_axis_tdata[23:12] * MAX_W + s_axis_tdata[11:0]] =
              s_axis_tdata[55:24];
        end else begin
          expected_pixels.push_back(resample_pixel(s_axis_tdata[11:0],
                                                   s_axis_tdata[23:12]));
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {req.pix, req.y, req.x};
          s_axis_tuser  <= req.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest prediction.
  always @(posedge clk) begin : monitor
    pixel_t got, want;
    string  names[4];
    names = '{"out_red", "out_green", "out_blue", "out_alpha"};
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transaction: %h", got);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got[8*k +: 8] != want[8*k +: 8]) begin
              $error("%s: expected %0d, actual %0d", names[k], want[8*k +: 8],
                     got[8*k +: 8]);
              mismatch_count++;
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (pressure_armed && !pressure_used) begin
        hold_left     <= HOLD_CYCLES;
        pressure_used <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SOURCE_WIDTH:  cfg_width  = value[SIZE_W-1:0];
      REG_SOURCE_HEIGHT: cfg_height = value[SIZE_W-1:0];
      REG_STEP_X:        cfg_step_x = value[STEP_W-1:0];
      REG_STEP_Y:        cfg_step_y = value[STEP_W-1:0];
      REG_FILTER_MODE:   cfg_filter = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (request_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                           input logic [STEP_W-1:0] sx, input logic [STEP_W-1:0] sy,
                           input logic mode, input idle_mode_t idle);
    wait_quiet();
    write_reg(REG_SOURCE_WIDTH, w);
    write_reg(REG_SOURCE_HEIGHT, h);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_FILTER_MODE, mode);
    region_w = eff_size(w, MAX_W);
    region_h = eff_size(h, MAX_H);
    send_idle_pct <= (idle == IDLE_SEND) ? 72 : (idle == IDLE_BOTH) ? 27 : 0;
    recv_idle_pct <= (idle == IDLE_RECV) ? 72 : (idle == IDLE_BOTH) ? 27 : 0;
  endtask

  task automatic push_store(input logic [11:0] x, input logic [11:0] y, input pixel_t pix);
    request_queue.push_back('{kind: KIND_STORE, y: y, x: x, pix: pix});
    if (x < MAX_W && y < MAX_H) begin
      filled[y * MAX_W + x] = 1'b1;
      item_count++;
    end
  endtask

  task automatic push_sample(input logic [11:0] x, input logic [11:0] y);
    request_queue.push_back('{kind: KIND_SAMPLE, y: y, x: x, pix: pixel_t'($urandom)});
    item_count++;
  endtask

  function automatic logic [11:0] pick_coord();
    return $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 31);
  endfunction

  // Write every pixel that samples of this setting can reach.
  task automatic fill_region();
    for (int y = 0; y < region_h; y++)
      for (int x = 0; x < region_w; x++)
        if (!filled[y * MAX_W + x]) push_store(x, y, pixel_t'($urandom));
  endtask

  task automatic run_random_phase(input int p);
    logic [SIZE_W-1:0] w, h;
    logic [STEP_W-1:0] sx, sy;
    logic              mode;
    int                r;
    w    = $urandom_range(1, 12);
    h    = $urandom_range(1, 12);
    sx   = $urandom_range(0, 24'h3FFFF);
    sy   = $urandom_range(0, 24'h3FFFF);
    mode = $urandom_range(0, 1);
    case (p)
      0: begin w = 9'd511; h = 9'd0; mode = FILTER_BILINEAR; end
      1: begin w = 9'd1; h = 9'd256; mode = FILTER_NEAREST; end
      2: begin sx = 24'hFFFFFF; sy = 24'h0; end
      3: begin sx = 24'h0; sy = 24'hFFFFFF; end
      default: ;
    endcase
    configure(w, h, sx, sy, mode, idle_mode_t'(p % 4));
    if (p == 2) pressure_armed <= 1'b1;
    fill_region();
    repeat (PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 75)
        push_sample(pick_coord(), pick_coord());
      else if (r < 90)
        push_store($urandom_range(0, region_w - 1), $urandom_range(0, region_h - 1),
                   pixel_t'($urandom));
      else if (r < 95)
        push_store($urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1),
                   pixel_t'($urandom));
      else if ($urandom_range(0, 1))
        push_store($urandom_range(0, 4095), $urandom_range(MAX_H, 4095), pixel_t'($urandom));
      else
        push_store($urandom_range(MAX_W, 4095), $urandom_range(0, 4095), pixel_t'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Bilinear on a 2x2 source, half and three-quarter steps.
    configure(9'd2, 9'd2, 24'h008000, 24'h00C000, FILTER_BILINEAR, IDLE_NONE);
    push_store(12'd0, 12'd0, pixel_t'(32'h0000_0000));
    push_store(12'd1, 12'd0, pixel_t'(32'hFFFF_FFFF));
    push_store(12'd0, 12'd1, pixel_t'(32'hFF00_FF00));
    push_store(12'd1, 12'd1, pixel_t'(32'h00FF_00FF));
    push_store(12'd4095, 12'd4095, pixel_t'(32'hDEAD_BEEF));
    push_store(12'd256, 12'd0, pixel_t'(32'h1234_5678));
    push_store(12'd0, 12'd256, pixel_t'(32'h8765_4321));
    push_store(12'd255, 12'd255, pixel_t'(32'hA5A5_5A5A));
    push_sample(12'd0, 12'd0);
    push_sample(12'd1, 12'd1);
    push_sample(12'd4095, 12'd4095);
    push_sample(12'd3, 12'd1);
    push_sample(12'd2, 12'd4095);
    push_sample(12'd1, 12'd0);

    // Zero size clamps everything to the first pixel.
    configure(9'd0, 9'd0, 24'h008000, 24'h008000, FILTER_NEAREST, IDLE_NONE);
    push_sample(12'd1, 12'd1);
    push_sample(12'd4095, 12'd0);

    // Nearest: exact half rounds up, just below half rounds down.
    configure(9'd2, 9'd2, 24'h008000, 24'h007FFF, FILTER_NEAREST, IDLE_NONE);
    push_sample(12'd1, 12'd1);
    push_sample(12'd2, 12'd2);
    push_sample(12'd4095, 12'd4095);
    push_sample(12'd0, 12'd0);

    // Zero step pins every coordinate to the origin.
    configure(9'd2, 9'd2, 24'h000000, 24'h000000, FILTER_BILINEAR, IDLE_NONE);
    push_sample(12'd4095, 12'd4095);

    for (int p = 0; item_count < ITEM_TARGET; p++)
      run_random_phase(p);

    wait_quiet();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ibr_pkg.sv
design/ibr_ram.sv
design/image_bilinear_resampler.sv
test/tb_image_bilinear_resampler.sv
